// ===== sv/rfft_pkg.sv =====
// ----------------------------------------------------------------------------
// rfft_pkg
// Shared constants, command/status types and twiddle helpers for the FFT.
// ----------------------------------------------------------------------------
package rfft_pkg;

  localparam int POINTS   = 64;
  localparam int ADDR_W   = 6;
  localparam int CNT_W    = 7;
  localparam int LG_W     = 3;
  localparam int BFLY_W   = 5;
  localparam int SAMPLE_W = 16;
  localparam int DATA_W   = 24;
  localparam int TW_W     = 17;
  localparam int TWK_W    = 5;
  localparam int FRAC_W   = 15;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_BR_RD,
    ST_BR_WA,
    ST_BR_WC,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_WA,
    ST_BF_WC,
    ST_OUT_RD,
    ST_OUT_DAT,
    ST_OUT_HOLD
  } state_e;

  typedef enum logic [2:0] {
    WR_SAMPLE,
    WR_SWAP_A,
    WR_SWAP_C,
    WR_SUM,
    WR_DIFF
  } wr_sel_e;

  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_a;
    logic [ADDR_W-1:0] rd_c;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    wr_sel_e           wr_sel;
    logic              mul_en;
    logic [TWK_W-1:0]  tw_k;
    logic              out_load;
    logic [ADDR_W-1:0] out_index;
    logic              out_last;
    logic              out_drop;
    logic [LG_W-1:0]   out_shift;
    logic              clear;
  } cmd_t;

  typedef struct packed {
    logic out_taken;
  } status_t;

  // cos(2*pi*k/64) in signed Q2.15 (17 bits), 1.0 held as 32768
  function automatic logic signed [TW_W-1:0] tw_cos(input logic [TWK_W-1:0] k);
    logic signed [TW_W-1:0] c;
    unique case (k)
      5'd0:  c = 17'sd32768;  5'd1:  c = 17'sd32610;
      5'd2:  c = 17'sd32138;  5'd3:  c = 17'sd31357;
      5'd4:  c = 17'sd30274;  5'd5:  c = 17'sd28899;
      5'd6:  c = 17'sd27246;  5'd7:  c = 17'sd25330;
      5'd8:  c = 17'sd23170;  5'd9:  c = 17'sd20788;
      5'd10: c = 17'sd18205;  5'd11: c = 17'sd15447;
      5'd12: c = 17'sd12540;  5'd13: c = 17'sd9512;
      5'd14: c = 17'sd6393;   5'd15: c = 17'sd3212;
      5'd16: c = 17'sd0;      5'd17: c = -17'sd3212;
      5'd18: c = -17'sd6393;  5'd19: c = -17'sd9512;
      5'd20: c = -17'sd12540; 5'd21: c = -17'sd15447;
      5'd22: c = -17'sd18205; 5'd23: c = -17'sd20788;
      5'd24: c = -17'sd23170; 5'd25: c = -17'sd25330;
      5'd26: c = -17'sd27246; 5'd27: c = -17'sd28899;
      5'd28: c = -17'sd30274; 5'd29: c = -17'sd31357;
      5'd30: c = -17'sd32138; 5'd31: c = -17'sd32610;
      default: c = 17'sd0;
    endcase
    return c;
  endfunction

  // sin(2*pi*k/64) = cos table at |k - 16|
  function automatic logic signed [TW_W-1:0] tw_sin(input logic [TWK_W-1:0] k);
    logic [TWK_W-1:0] d;
    d = (k >= 5'd16) ? (k - 5'd16) : (5'd16 - k);
    return tw_cos(d);
  endfunction

  // ceil(log2(count)), count 1..64
  function automatic logic [LG_W-1:0] size_log2(input logic [CNT_W-1:0] count);
    logic [LG_W-1:0] lg;
    lg = '0;
    for (int b = 0; b < ADDR_W; b++) begin
      if ((CNT_W'(1) << b) < count) lg = LG_W'(b + 1);
    end
    return lg;
  endfunction

  // reverse the low lg bits of idx
  function automatic logic [ADDR_W-1:0] bit_rev(input logic [ADDR_W-1:0] idx,
                                                 input logic [LG_W-1:0]   lg);
    logic [ADDR_W-1:0] r;
    for (int b = 0; b < ADDR_W; b++) r[b] = idx[ADDR_W-1-b];
    return r >> (LG_W'(ADDR_W) - lg);
  endfunction

endpackage

// ===== sv/rfft_dp.sv =====
// ----------------------------------------------------------------------------
// rfft_dp
// Frame memory, butterfly arithmetic, output scaling and output register.
// ----------------------------------------------------------------------------
module rfft_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic                  cfg_wdata_i,
  input  logic signed [15:0]    sample_re_i,
  input  logic signed [15:0]    sample_im_i,
  input  rfft_pkg::cmd_t        cmd_i,
  output rfft_pkg::status_t     status_o,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output logic signed [23:0]    bin_re_o,
  output logic signed [23:0]    bin_im_o,
  output logic [5:0]            bin_index_o,
  output logic                  bin_last_o,
  output logic                  too_many_samples_o
);

  localparam int DW  = rfft_pkg::DATA_W;
  localparam int SW  = rfft_pkg::SAMPLE_W;
  localparam int PW  = rfft_pkg::DATA_W + rfft_pkg::TW_W;
  localparam int OW  = rfft_pkg::DATA_W + 2;
  localparam int FW  = rfft_pkg::FRAC_W;

  logic [2*DW-1:0]               mem [rfft_pkg::POINTS];
  logic [rfft_pkg::POINTS-1:0]   vld_q;
  logic [2*DW-1:0]               rd_a_q, rd_c_q;
  logic                          rd_a_vld_q, rd_c_vld_q;
  logic                          inverse_q;

  logic signed [DW-1:0] a_re, a_im, c_re, c_im;
  logic signed [DW-1:0] ld_re, ld_im;
  logic signed [rfft_pkg::TW_W-1:0] tw_c, tw_s;
  logic signed [PW-1:0] p_rr_q, p_is_q, p_rs_q, p_ir_q;
  logic signed [DW-1:0] u_re_q, u_im_q, d_re_q, d_im_q;
  logic signed [PW:0]   t_re_full, t_im_full;
  logic signed [DW-1:0] t_re, t_im, s_re, s_im, x_re, x_im;
  logic [2*DW-1:0]      wdata;
  logic signed [OW-1:0] o_re, o_im, o_re_sh, o_im_sh;
  logic [rfft_pkg::LG_W-1:0] shift;
  logic out_valid_q;

  function automatic logic signed [OW-1:0] round_shift(input logic signed [OW-1:0] v,
                                                       input logic [rfft_pkg::LG_W-1:0] s);
    logic signed [OW-1:0] t;
    if (s == '0) return v;
    t = v + (OW'(1) << (s - 1'b1));
    return t >>> s;
  endfunction

  function automatic logic signed [DW-1:0] sat(input logic signed [OW-1:0] v);
    if (v > OW'(8388607)) return 24'sh7FFFFF;
    if (v < -(OW'(8388608))) return 24'sh800000;
    return v[DW-1:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inverse_q <= 1'b0;
    end else if (cfg_we_i) begin
      inverse_q <= cfg_wdata_i;
    end
  end

  // read data of never-written entries is zero
  assign a_re = rd_a_vld_q ? rd_a_q[2*DW-1:DW] : '0;
  assign a_im = rd_a_vld_q ? rd_a_q[DW-1:0]    : '0;
  assign c_re = rd_c_vld_q ? rd_c_q[2*DW-1:DW] : '0;
  assign c_im = rd_c_vld_q ? rd_c_q[DW-1:0]    : '0;

  assign ld_re = {{(DW-SW){sample_re_i[SW-1]}}, sample_re_i};
  assign ld_im = inverse_q ? -{{(DW-SW){sample_im_i[SW-1]}}, sample_im_i}
                           :  {{(DW-SW){sample_im_i[SW-1]}}, sample_im_i};

  assign tw_c = rfft_pkg::tw_cos(cmd_i.tw_k);
  assign tw_s = rfft_pkg::tw_sin(cmd_i.tw_k);

  // t = (cos - j sin) * b, rounded back to integer units
  always_comb begin
    t_re_full = (PW+1)'(p_rr_q) + (PW+1)'(p_is_q) + ((PW+1)'(1) << (FW - 1));
    t_im_full = (PW+1)'(p_ir_q) - (PW+1)'(p_rs_q) + ((PW+1)'(1) << (FW - 1));
    t_re = DW'(t_re_full >>> FW);
    t_im = DW'(t_im_full >>> FW);
    s_re = u_re_q + t_re;
    s_im = u_im_q + t_im;
    x_re = u_re_q - t_re;
    x_im = u_im_q - t_im;
  end

  always_comb begin
    case (cmd_i.wr_sel)
      rfft_pkg::WR_SAMPLE: wdata = {ld_re, ld_im};
      rfft_pkg::WR_SWAP_A: wdata = {c_re, c_im};
      rfft_pkg::WR_SWAP_C: wdata = {a_re, a_im};
      rfft_pkg::WR_SUM:    wdata = {s_re, s_im};
      rfft_pkg::WR_DIFF:   wdata = {d_re_q, d_im_q};
      default:             wdata = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) mem[cmd_i.wr_addr] <= wdata;
    if (cmd_i.rd_en) begin
      rd_a_q <= mem[cmd_i.rd_a];
      rd_c_q <= mem[cmd_i.rd_c];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q      <= '0;
      rd_a_vld_q <= 1'b0;
      rd_c_vld_q <= 1'b0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_a_vld_q <= vld_q[cmd_i.rd_a];
        rd_c_vld_q <= vld_q[cmd_i.rd_c];
      end
      if (cmd_i.clear) begin
        vld_q <= '0;
      end else if (cmd_i.wr_en) begin
        vld_q[cmd_i.wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      p_rr_q <= c_re * tw_c;
      p_is_q <= c_im * tw_s;
      p_rs_q <= c_re * tw_s;
      p_ir_q <= c_im * tw_c;
      u_re_q <= a_re;
      u_im_q <= a_im;
    end
    if (cmd_i.wr_en && cmd_i.wr_sel == rfft_pkg::WR_SUM) begin
      d_re_q <= x_re;
      d_im_q <= x_im;
    end
  end

  // output conjugation and 1/n scaling in inverse mode
  always_comb begin
    shift   = inverse_q ? cmd_i.out_shift : '0;
    o_re    = {{(OW-DW){a_re[DW-1]}}, a_re};
    o_im    = inverse_q ? -{{(OW-DW){a_im[DW-1]}}, a_im} : {{(OW-DW){a_im[DW-1]}}, a_im};
    o_re_sh = round_shift(o_re, shift);
    o_im_sh = round_shift(o_im, shift);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      bin_re_o           <= sat(o_re_sh);
      bin_im_o           <= sat(o_im_sh);
      bin_index_o        <= cmd_i.out_index;
      bin_last_o         <= cmd_i.out_last;
      too_many_samples_o <= cmd_i.out_drop;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign status_o.out_taken = out_valid_q & ~out_stall_i;

endmodule

// ===== sv/rfft_ctrl.sv =====
// ----------------------------------------------------------------------------
// rfft_ctrl
// Sequencer: load, bit-reverse pass, butterfly stages, bin readout.
// ----------------------------------------------------------------------------
module rfft_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               frame_end_i,
  output logic               in_stall_o,
  input  rfft_pkg::status_t  status_i,
  output rfft_pkg::cmd_t     cmd_o
);

  localparam int AW = rfft_pkg::ADDR_W;
  localparam int CW = rfft_pkg::CNT_W;
  localparam int LW = rfft_pkg::LG_W;
  localparam int BW = rfft_pkg::BFLY_W;

  rfft_pkg::state_e state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic          drop_q, drop_d;
  logic [LW-1:0] lg_q, lg_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [LW-1:0] stage_q, stage_d;
  logic [BW-1:0] bfly_q, bfly_d;

  logic          accept, room;
  logic [AW-1:0] n_m1, rev;
  logic [BW-1:0] half_n_m1, half_m1, jj;
  logic [AW-1:0] addr_a, addr_c;
  logic          br_swap, br_done, bf_last, out_last;

  assign accept = in_valid_i && (state_q == rfft_pkg::ST_LOAD);
  assign room   = count_q < CW'(rfft_pkg::POINTS);

  always_comb begin
    n_m1      = AW'((CW'(1) << lg_q) - CW'(1));
    half_n_m1 = BW'(n_m1 >> 1);
    rev       = rfft_pkg::bit_rev(idx_q, lg_q);
    br_swap   = idx_q < rev;
    br_done   = idx_q == n_m1;
    // butterfly index -> pair addresses for stage with span 2^stage
    half_m1   = BW'((CW'(1) << (stage_q - 1'b1)) - CW'(1));
    jj        = bfly_q & half_m1;
    addr_a    = AW'({1'b0, bfly_q & ~half_m1} << 1) | AW'(jj);
    addr_c    = addr_a | AW'({1'b0, half_m1} + 6'd1);
    bf_last   = (bfly_q == half_n_m1) && (stage_q == lg_q);
    out_last  = idx_q == n_m1;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rfft_pkg::ST_LOAD:
        if (accept && frame_end_i) state_d = rfft_pkg::ST_BR_RD;
      rfft_pkg::ST_BR_RD:
        if (br_swap) state_d = rfft_pkg::ST_BR_WA;
        else if (br_done) state_d = (lg_q == '0) ? rfft_pkg::ST_OUT_RD : rfft_pkg::ST_BF_RD;
      rfft_pkg::ST_BR_WA: state_d = rfft_pkg::ST_BR_WC;
      rfft_pkg::ST_BR_WC:
        if (br_done) state_d = (lg_q == '0) ? rfft_pkg::ST_OUT_RD : rfft_pkg::ST_BF_RD;
        else state_d = rfft_pkg::ST_BR_RD;
      rfft_pkg::ST_BF_RD:  state_d = rfft_pkg::ST_BF_MUL;
      rfft_pkg::ST_BF_MUL: state_d = rfft_pkg::ST_BF_WA;
      rfft_pkg::ST_BF_WA:  state_d = rfft_pkg::ST_BF_WC;
      rfft_pkg::ST_BF_WC:
        state_d = bf_last ? rfft_pkg::ST_OUT_RD : rfft_pkg::ST_BF_RD;
      rfft_pkg::ST_OUT_RD:  state_d = rfft_pkg::ST_OUT_DAT;
      rfft_pkg::ST_OUT_DAT: state_d = rfft_pkg::ST_OUT_HOLD;
      rfft_pkg::ST_OUT_HOLD:
        if (status_i.out_taken) state_d = out_last ? rfft_pkg::ST_LOAD : rfft_pkg::ST_OUT_RD;
      default: state_d = rfft_pkg::ST_LOAD;
    endcase
  end

  // commands and counters
  always_comb begin
    cmd_o     = '0;
    cmd_o.wr_sel    = rfft_pkg::WR_SAMPLE;
    cmd_o.tw_k      = rfft_pkg::TWK_W'(jj << (LW'(AW) - stage_q));
    cmd_o.out_index = idx_q;
    cmd_o.out_last  = out_last;
    cmd_o.out_drop  = drop_q;
    cmd_o.out_shift = lg_q;
    count_d = count_q;
    drop_d  = drop_q;
    lg_d    = lg_q;
    idx_d   = idx_q;
    stage_d = stage_q;
    bfly_d  = bfly_q;
    unique case (state_q)
      rfft_pkg::ST_LOAD: begin
        if (accept) begin
          if (room) begin
            cmd_o.wr_en   = 1'b1;
            cmd_o.wr_addr = count_q[AW-1:0];
            count_d       = count_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          lg_d    = rfft_pkg::size_log2(count_d);
          idx_d   = '0;
          stage_d = LW'(1);
          bfly_d  = '0;
        end
      end
      rfft_pkg::ST_BR_RD: begin
        cmd_o.rd_a = idx_q;
        cmd_o.rd_c = rev;
        if (br_swap) cmd_o.rd_en = 1'b1;
        else if (!br_done) idx_d = idx_q + 1'b1;
        else idx_d = '0;
      end
      rfft_pkg::ST_BR_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = idx_q;
        cmd_o.wr_sel  = rfft_pkg::WR_SWAP_A;
      end
      rfft_pkg::ST_BR_WC: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = rev;
        cmd_o.wr_sel  = rfft_pkg::WR_SWAP_C;
        idx_d         = br_done ? '0 : idx_q + 1'b1;
      end
      rfft_pkg::ST_BF_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_a  = addr_a;
        cmd_o.rd_c  = addr_c;
      end
      rfft_pkg::ST_BF_MUL: cmd_o.mul_en = 1'b1;
      rfft_pkg::ST_BF_WA: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr_a;
        cmd_o.wr_sel  = rfft_pkg::WR_SUM;
      end
      rfft_pkg::ST_BF_WC: begin
        cmd_o.wr_en   = 1'b1;
        cmd_o.wr_addr = addr_c;
        cmd_o.wr_sel  = rfft_pkg::WR_DIFF;
        if (bfly_q == half_n_m1) begin
          bfly_d  = '0;
          stage_d = stage_q + 1'b1;
        end else begin
          bfly_d = bfly_q + 1'b1;
        end
        idx_d = '0;
      end
      rfft_pkg::ST_OUT_RD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.rd_a  = idx_q;
        cmd_o.rd_c  = idx_q;
      end
      rfft_pkg::ST_OUT_DAT: cmd_o.out_load = 1'b1;
      rfft_pkg::ST_OUT_HOLD: begin
        if (status_i.out_taken) begin
          if (out_last) begin
            cmd_o.clear = 1'b1;
            count_d     = '0;
            drop_d      = 1'b0;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rfft_pkg::ST_LOAD;
      count_q <= '0;
      drop_q  <= 1'b0;
      lg_q    <= '0;
      idx_q   <= '0;
      stage_q <= LW'(1);
      bfly_q  <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      drop_q  <= drop_d;
      lg_q    <= lg_d;
      idx_q   <= idx_d;
      stage_q <= stage_d;
      bfly_q  <= bfly_d;
    end
  end

  assign in_stall_o = state_q != rfft_pkg::ST_LOAD;

endmodule

// ===== sv/radix2_fft_frame.sv =====
// ----------------------------------------------------------------------------
// radix2_fft_frame
// Framed radix-2 decimation-in-time FFT, up to 64 points, fixed point.
// ----------------------------------------------------------------------------
//  channel | signals                                      | dir
//  --------+----------------------------------------------+-----
//  sample  | in_valid_i / in_stall_o, sample_re/im, end   | in
//  bin     | out_valid_o / out_stall_i, bin_*, flag       | out
//  config  | cfg_we_i, cfg_wdata_i (inverse_mode)         | in
//
//  A sample request is taken whenever in_valid_i is high while loading. On
//  frame end the frame (n = 2^ceil(log2(count)) points) is bit-reversed in
//  place, each swap as one read of both entries and two writes. Butterflies
//  run on one shared unit through a single-write frame memory, each as read,
//  multiply, sum write and difference write; there are (n/2)*log2(n) of them.
//  Each bin is then read, registered and held until taken. Reset needs no
//  clearing pass: per-entry valid bits make unwritten entries read as zero.
// ----------------------------------------------------------------------------
module radix2_fft_frame (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_re_i,
  input  logic signed [15:0] sample_im_i,
  input  logic               frame_end_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [23:0] bin_re_o,
  output logic signed [23:0] bin_im_o,
  output logic [5:0]         bin_index_o,
  output logic               bin_last_o,
  output logic               too_many_samples_o
);

  rfft_pkg::cmd_t    cmd;
  rfft_pkg::status_t status;

  // sequencer: sample count, drop flag, pass/stage/butterfly counters
  rfft_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .frame_end_i (frame_end_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // frame memory, butterfly unit, output scaling and result register
  rfft_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_we_i           (cfg_we_i),
    .cfg_wdata_i        (cfg_wdata_i),
    .sample_re_i        (sample_re_i),
    .sample_im_i        (sample_im_i),
    .cmd_i              (cmd),
    .status_o           (status),
    .out_stall_i        (out_stall_i),
    .out_valid_o        (out_valid_o),
    .bin_re_o           (bin_re_o),
    .bin_im_o           (bin_im_o),
    .bin_index_o        (bin_index_o),
    .bin_last_o         (bin_last_o),
    .too_many_samples_o (too_many_samples_o)
  );

endmodule
